/* design/isur_pkg.sv */
package isur_pkg;

  // register byte addresses on the configuration port
  localparam int unsigned ADDR_W = 4;
  localparam logic [ADDR_W-1:0] ADDR_ENABLE     = 4'h0;
  localparam logic [ADDR_W-1:0] ADDR_BIT_PERIOD = 4'h4;
  localparam logic [ADDR_W-1:0] ADDR_FIRST_DLY  = 4'h8;

  // frame format
  localparam int unsigned DATA_BITS = 8;
  localparam int unsigned COUNT_W   = 4;
  localparam int unsigned TICK_W    = 16;
  localparam logic [DATA_BITS-1:0] TOP_BIT = 8'h80;

  // register reset values
  localparam logic [TICK_W-1:0] BIT_PERIOD_RST = 16'd17;
  localparam logic [TICK_W-1:0] FIRST_DLY_RST  = 16'd25;

  typedef struct packed {
    logic              enable;
    logic [TICK_W-1:0] bit_period;
    logic [TICK_W-1:0] first_sample_delay;
  } isur_cfg_t;

  typedef struct packed {
    logic                 valid;
    logic [DATA_BITS-1:0] data;
  } isur_res_t;

endpackage

/* design/isur_rx.sv */
module isur_rx
  import isur_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      tick_valid,
  input  logic      tick_level,
  input  isur_cfg_t cfg,
  input  logic      clear,
  output isur_res_t res
);

  logic                 prev_level_r, prev_level_nxt;
  logic                 receiving_r, receiving_nxt;
  logic [COUNT_W-1:0]   bits_taken_r, bits_taken_nxt;
  logic [DATA_BITS-1:0] shift_r, shift_nxt;
  logic [TICK_W-1:0]    tick_count_r, tick_count_nxt;

  logic [TICK_W-1:0]    tick_inc;
  logic [TICK_W-1:0]    target;
  logic [DATA_BITS-1:0] shifted;

  assign tick_inc = tick_count_r + 1'b1;
  assign target   = (bits_taken_r == '0) ? cfg.first_sample_delay : cfg.bit_period;
  assign shifted  = (bits_taken_r == '0) ? '0 : (shift_r >> 1);

  // one tick of the receiver
  always_comb begin
    prev_level_nxt = prev_level_r;
    receiving_nxt  = receiving_r;
    bits_taken_nxt = bits_taken_r;
    shift_nxt      = shift_r;
    tick_count_nxt = tick_count_r;
    res.valid      = 1'b0;
    res.data       = shift_r;
    if (tick_valid) begin
      prev_level_nxt = tick_level;
      if (!cfg.enable) begin
        receiving_nxt  = 1'b0;
        bits_taken_nxt = '0;
        shift_nxt      = '0;
        tick_count_nxt = '0;
      end else if (!receiving_r) begin
        // start bit shows as a rising edge on the inverted line
        if (tick_level && !prev_level_r) begin
          receiving_nxt  = 1'b1;
          bits_taken_nxt = '0;
          tick_count_nxt = '0;
        end
      end else if (tick_inc != target) begin
        tick_count_nxt = tick_inc;
      end else begin
        tick_count_nxt = '0;
        if (bits_taken_r < COUNT_W'(DATA_BITS)) begin
          // sample inverted, shifted in from the top
          shift_nxt      = tick_level ? shifted : (shifted | TOP_BIT);
          bits_taken_nxt = bits_taken_r + 1'b1;
        end else begin
          res.valid      = 1'b1;
          receiving_nxt  = 1'b0;
          bits_taken_nxt = '0;
        end
      end
    end
    // disabling by register write drops any progress
    if (clear) begin
      receiving_nxt  = 1'b0;
      bits_taken_nxt = '0;
      shift_nxt      = '0;
      tick_count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r <= 1'b0;
      receiving_r  <= 1'b0;
      bits_taken_r <= '0;
      shift_r      <= '0;
      tick_count_r <= '0;
    end else begin
      prev_level_r <= prev_level_nxt;
      receiving_r  <= receiving_nxt;
      bits_taken_r <= bits_taken_nxt;
      shift_r      <= shift_nxt;
      tick_count_r <= tick_count_nxt;
    end
  end

endmodule

/* design/inverted_soft_uart_receiver_core.sv */
// Timer-sampled receiver for an inverted 8-bit serial line.
// Input channel: one beat per line tick (in_valid / in_stall, in_line_level).
// Output channel: one beat per received byte (out_valid / out_stall,
// out_received_byte), least significant bit first, bits inverted from the line.
// Configuration: APB-style port, enable at 0x0, bit_period at 0x4,
// first_sample_delay at 0x8; pready is tied high, reads return the registers.
// Throughput: one tick accepted every cycle while in_stall is low; the tick
// state update is a single compare and increment of the 16-bit tick counter.
// A byte is registered in the output register, or in the skid entry if full.
// Reset (rst_n, synchronous): receiver idle, enable 0, bit_period 17,
// first_sample_delay 25, output empty.
// Stalling: the output register plus one skid entry hold results; in_stall
// rises only while both are full, so ticks keep flowing while one byte waits.
module inverted_soft_uart_receiver_core
  import isur_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_line_level,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DATA_BITS-1:0] out_received_byte,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  isur_cfg_t cfg_r, cfg_nxt;
  logic      cfg_wr;
  logic      clear;
  logic      tick_acc;
  isur_res_t res;

  logic                 out_valid_r, out_valid_nxt;
  logic [DATA_BITS-1:0] out_byte_r, out_byte_nxt;
  logic                 skid_valid_r, skid_valid_nxt;
  logic [DATA_BITS-1:0] skid_byte_r, skid_byte_nxt;

  // register access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign clear  = cfg_wr && (paddr == ADDR_ENABLE) && !pwdata[0];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (paddr)
        ADDR_ENABLE:     cfg_nxt.enable             = pwdata[0];
        ADDR_BIT_PERIOD: cfg_nxt.bit_period         = pwdata[TICK_W-1:0];
        ADDR_FIRST_DLY:  cfg_nxt.first_sample_delay = pwdata[TICK_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      ADDR_ENABLE:     prdata = {31'd0, cfg_r.enable};
      ADDR_BIT_PERIOD: prdata = {16'd0, cfg_r.bit_period};
      ADDR_FIRST_DLY:  prdata = {16'd0, cfg_r.first_sample_delay};
      default:         prdata = '0;
    endcase
  end

  // tick processing
  assign in_stall = skid_valid_r;
  assign tick_acc = in_valid && !in_stall;

  isur_rx u_rx (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_valid (tick_acc),
    .tick_level (in_line_level),
    .cfg        (cfg_r),
    .clear      (clear),
    .res        (res)
  );

  // output register with one skid entry
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_byte_nxt   = out_byte_r;
    skid_valid_nxt = skid_valid_r;
    skid_byte_nxt  = skid_byte_r;
    if (out_valid_r && !out_stall) begin
      if (skid_valid_r) begin
        out_byte_nxt   = skid_byte_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
    if (res.valid) begin
      if (!out_valid_nxt) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = res.data;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_byte_nxt  = res.data;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_received_byte = out_byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable             <= 1'b0;
      cfg_r.bit_period         <= BIT_PERIOD_RST;
      cfg_r.first_sample_delay <= FIRST_DLY_RST;
      out_valid_r              <= 1'b0;
      skid_valid_r             <= 1'b0;
    end else begin
      cfg_r        <= cfg_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r  <= out_byte_nxt;
    skid_byte_r <= skid_byte_nxt;
  end

endmodule
